// ----- rtl/pvdae_pkg.sv -----
// ----------------------------------------------------------------------------
// pvdae_pkg
// Shared constants, opcodes and types of the audio pair embedder.
// ----------------------------------------------------------------------------
package pvdae_pkg;

  localparam int HEADER_BITS_DEF   = 10;
  localparam int MAX_MESSAGE_BYTES = 128;
  localparam int BYTE_ADDR_W       = $clog2(MAX_MESSAGE_BYTES);
  localparam int PAYLOAD_W         = 7;
  localparam int POS_W             = 11;
  localparam int SAMPLE_W          = 16;
  localparam int CAP_W             = 4;
  localparam int MAX_CAP           = 15;

  // message store banking: three consecutive bytes always hit three banks
  localparam int BANKS       = 4;
  localparam int BANK_SEL_W  = $clog2(BANKS);
  localparam int BANK_DEPTH  = MAX_MESSAGE_BYTES / BANKS;
  localparam int BANK_ADDR_W = $clog2(BANK_DEPTH);
  localparam int WIN_BYTES   = 3;
  localparam int WIN_BITS    = WIN_BYTES * 8;
  localparam int WIN_IDX_W   = $clog2(WIN_BITS);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EMBED   = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef struct packed {
    logic                   en;
    logic [BYTE_ADDR_W-1:0] addr;
    logic [7:0]             data;
  } msg_wr_t;

endpackage

// ----- rtl/pvdae_ifs.sv -----
// ----------------------------------------------------------------------------
// pvdae channel interfaces
// Valid/ready channels for configuration, sample pairs and results.
// ----------------------------------------------------------------------------
interface pvdae_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] payload_bytes;

  modport source (output valid, output payload_bytes, input ready);
  modport sink   (input valid, input payload_bytes, output ready);
endinterface

interface pvdae_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [6:0]         byte_index;
  logic [7:0]         message_byte;
  logic signed [15:0] first_sample;
  logic signed [15:0] second_sample;

  modport source (output valid, output opcode, output byte_index, output message_byte,
                  output first_sample, output second_sample, input ready);
  modport sink   (input valid, input opcode, input byte_index, input message_byte,
                  input first_sample, input second_sample, output ready);
endinterface

interface pvdae_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_out;
  logic signed [15:0] second_out;
  logic [3:0]         bits_used;
  logic               final_bits;
  logic               passed_through;

  modport source (output valid, output first_out, output second_out, output bits_used,
                  output final_bits, output passed_through, input ready);
  modport sink   (input valid, input first_out, input second_out, input bits_used,
                  input final_bits, input passed_through, output ready);
endinterface

// ----- rtl/pvdae_msg_store.sv -----
// ----------------------------------------------------------------------------
// pvdae_msg_store
// Four-bank message byte store; returns the three bytes starting at a base.
// ----------------------------------------------------------------------------
module pvdae_msg_store import pvdae_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  msg_wr_t                wr,
  input  logic [BYTE_ADDR_W-1:0] rd_base,
  output logic [WIN_BITS-1:0]    window
);

  logic [BANKS-1:0][7:0]  bank_data;
  logic [BYTE_ADDR_W-1:0] rd_base_q;
  msg_wr_t                wr_q;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [7:0]             mem [BANK_DEPTH];
    logic [7:0]             q;
    logic [BANK_SEL_W-1:0]  off;
    logic [BYTE_ADDR_W-1:0] addr_x;

    // byte of the window that lives in this bank
    assign off    = BANK_SEL_W'(b) - rd_base[BANK_SEL_W-1:0];
    assign addr_x = rd_base + BYTE_ADDR_W'(off);

    always_ff @(posedge clk) begin
      if (wr.en && (wr.addr[BANK_SEL_W-1:0] == BANK_SEL_W'(b))) begin
        mem[wr.addr[BYTE_ADDR_W-1:BANK_SEL_W]] <= wr.data;
      end
      q <= mem[addr_x[BYTE_ADDR_W-1:BANK_SEL_W]];
    end

    assign bank_data[b] = q;
  end

  always_ff @(posedge clk) begin
    rd_base_q <= rd_base;
    if (rst) begin
      wr_q.en <= 1'b0;
    end else begin
      wr_q.en <= wr.en;
    end
    wr_q.addr <= wr.addr;
    wr_q.data <= wr.data;
  end

  // reorder banks into window order; forward a write that raced the read
  always_comb begin
    logic [BANK_SEL_W-1:0]  sel;
    logic [BYTE_ADDR_W-1:0] baddr;
    logic [7:0]             w;
    window = '0;
    for (int j = 0; j < WIN_BYTES; j++) begin
      sel   = rd_base_q[BANK_SEL_W-1:0] + BANK_SEL_W'(j);
      baddr = rd_base_q + BYTE_ADDR_W'(j);
      w     = bank_data[sel];
      if (wr_q.en && (wr_q.addr == baddr)) begin
        w = wr_q.data;
      end
      window[WIN_BITS-1-8*j -: 8] = w;
    end
  end

endmodule

// ----- rtl/pvd_audio_pair_embedder_core.sv -----
// ----------------------------------------------------------------------------
// pvd_audio_pair_embedder_core
// Differencing embedder that hides a length header and message in sample pairs.
// ----------------------------------------------------------------------------
// Load the message bytes (opcode load), set payload_bytes, then stream sample
// pairs (opcode embed). Each pair returns one result item after it passes the
// input register, one pass of difference/capacity logic and the result
// register; one item is taken every cycle as long as results are drained. The
// message store reads the three-byte window for the next bit position in the
// same cycle that the position moves, so the next pair finds its bits ready.
// Loads and restarts give no result. After the last message bit is placed,
// pairs pass through unchanged until a restart item. The store needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module pvd_audio_pair_embedder_core import pvdae_pkg::*; #(
  parameter int HEADER_BITS = HEADER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pvdae_cfg_if.sink   cfg,
  pvdae_in_if.sink    samples,
  pvdae_out_if.source results
);

  localparam int                HDR_IDX_W = $clog2(HEADER_BITS);
  localparam logic [POS_W-1:0]  HDR_LEN   = POS_W'(HEADER_BITS);

  // configuration
  logic [PAYLOAD_W-1:0] payload_bytes;

  // input register
  logic                   s1_valid;
  logic [1:0]             s1_op;
  logic [BYTE_ADDR_W-1:0] s1_index;
  logic [7:0]             s1_byte;
  logic signed [15:0]     s1_first;
  logic signed [15:0]     s1_second;

  // stream state
  logic [POS_W-1:0] bit_position, bit_position_next;
  logic             finished, finished_next;

  // result register
  logic               out_valid, out_valid_next;
  logic signed [15:0] out_first;
  logic signed [15:0] out_second;
  logic [CAP_W-1:0]   out_bits;
  logic               out_final;
  logic               out_passed;

  logic s1_embed, s1_fire;

  // store
  msg_wr_t                wr;
  logic [BYTE_ADDR_W-1:0] rd_base, cur_base;
  logic [WIN_BITS-1:0]    window;

  // embed datapath
  logic signed [16:0]     diff;
  logic [15:0]            mag;
  logic [CAP_W-1:0]       msb_k, cap, take;
  logic [15:0]            bound;
  logic [POS_W-1:0]       total, remaining;
  logic                   last;
  logic [HEADER_BITS-1:0] count_h;
  logic [MAX_CAP-1:0]     stream;
  logic [MAX_CAP-1:0]     value;
  logic [16:0]            target_mag;
  logic signed [17:0]     target, change, floor_h, half, fsub;
  logic signed [15:0]     first_new, second_new;

  // byte address of the first payload byte the window must cover
  function automatic logic [BYTE_ADDR_W-1:0] base_of(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    q = (p >= HDR_LEN) ? p - HDR_LEN : '0;
    return q[BYTE_ADDR_W+2:3];
  endfunction

  // --------------------------------------------------------------------------
  // Handshakes: the stage advances unless it holds a pair and the result
  // register is full and stalled.
  // --------------------------------------------------------------------------
  assign s1_embed      = s1_valid && (s1_op == OP_EMBED);
  assign s1_fire       = s1_valid && (!s1_embed || !out_valid || results.ready);
  assign samples.ready = !s1_valid || s1_fire;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes <= '0;
    end else if (cfg.valid) begin
      payload_bytes <= cfg.payload_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
    if (samples.valid && samples.ready) begin
      s1_op     <= samples.opcode;
      s1_index  <= samples.byte_index;
      s1_byte   <= samples.message_byte;
      s1_first  <= samples.first_sample;
      s1_second <= samples.second_sample;
    end
  end

  // --------------------------------------------------------------------------
  // Capacity: magnitude of the difference picks the range.
  // --------------------------------------------------------------------------
  assign diff = $signed({s1_second[15], s1_second}) - $signed({s1_first[15], s1_first});
  assign mag  = diff[16] ? 16'(-diff) : 16'(diff);

  always_comb begin
    msb_k = CAP_W'(3);
    for (int i = 4; i < 16; i++) begin
      if (mag[i]) begin
        msb_k = CAP_W'(i);
      end
    end
  end

  assign cap   = (mag[15:3] == '0) ? CAP_W'(3) : msb_k;
  assign bound = (mag[15:3] == '0) ? 16'd0 : (16'd1 << msb_k);

  // --------------------------------------------------------------------------
  // Bits left in header plus payload; the pair that reaches the end is last.
  // --------------------------------------------------------------------------
  assign total     = HDR_LEN + POS_W'({payload_bytes, 3'b000});
  assign remaining = (bit_position < total) ? total - bit_position : '0;
  assign last      = remaining <= POS_W'(cap);
  assign take      = last ? remaining[CAP_W-1:0] : cap;

  // --------------------------------------------------------------------------
  // Gather the next bits: header bits from the count, payload bits from the
  // prefetched window, then keep the first take of them.
  // --------------------------------------------------------------------------
  assign count_h  = HEADER_BITS'({payload_bytes, 3'b000});
  assign cur_base = base_of(bit_position);

  always_comb begin
    logic [POS_W:0]         pos;
    logic [POS_W:0]         qi;
    logic [HDR_IDX_W-1:0]   hidx;
    logic [WIN_IDX_W-1:0]   off;
    stream = '0;
    for (int i = 0; i < MAX_CAP; i++) begin
      pos  = {1'b0, bit_position} + (POS_W+1)'(i);
      qi   = pos - {1'b0, HDR_LEN};
      hidx = HDR_IDX_W'(HEADER_BITS - 1) - pos[HDR_IDX_W-1:0];
      off  = qi[WIN_IDX_W-1:0] - {cur_base[1:0], 3'b000};
      if (pos < {1'b0, HDR_LEN}) begin
        stream[MAX_CAP-1-i] = count_h[hidx];
      end else begin
        stream[MAX_CAP-1-i] = window[WIN_IDX_W'(WIN_BITS - 1) - off];
      end
    end
  end

  assign value = stream >> (CAP_W'(MAX_CAP) - take);

  // --------------------------------------------------------------------------
  // New difference keeps the old sign; split the change over both samples,
  // the odd unit going to the first sample.
  // --------------------------------------------------------------------------
  assign target_mag = {2'b00, value} + {1'b0, bound};
  assign target     = diff[16] ? -$signed({1'b0, target_mag}) : $signed({1'b0, target_mag});
  assign change     = target - 18'(diff);
  assign floor_h    = change >>> 1;
  assign half       = floor_h + 18'(change[17] && change[0]);
  assign fsub       = floor_h + 18'(!change[17] && change[0]);
  assign first_new  = s1_first - fsub[15:0];
  assign second_new = s1_second + half[15:0];

  // --------------------------------------------------------------------------
  // State update and store write.
  // --------------------------------------------------------------------------
  always_comb begin
    bit_position_next = bit_position;
    finished_next     = finished;
    wr.en             = 1'b0;
    wr.addr           = s1_index;
    wr.data           = s1_byte;
    if (s1_fire) begin
      unique case (s1_op)
        OP_LOAD: begin
          wr.en = 1'b1;
        end
        OP_EMBED: begin
          if (!finished) begin
            bit_position_next = bit_position + POS_W'(take);
            finished_next     = last;
          end
        end
        OP_RESTART: begin
          bit_position_next = '0;
          finished_next     = 1'b0;
        end
        default: begin
          // unused opcode: drop the item
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
      finished     <= 1'b0;
    end else begin
      bit_position <= bit_position_next;
      finished     <= finished_next;
    end
  end

  // read the window for the position the next pair will see
  assign rd_base = rst ? '0 : base_of(bit_position_next);

  pvdae_msg_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_base (rd_base),
    .window  (window)
  );

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_next = out_valid;
    if (s1_fire && s1_embed) begin
      out_valid_next = 1'b1;
    end else if (results.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (s1_fire && s1_embed) begin
      if (finished) begin
        out_first  <= s1_first;
        out_second <= s1_second;
        out_bits   <= '0;
        out_final  <= 1'b0;
        out_passed <= 1'b1;
      end else begin
        out_first  <= first_new;
        out_second <= second_new;
        out_bits   <= take;
        out_final  <= last;
        out_passed <= 1'b0;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.first_out      = out_first;
  assign results.second_out     = out_second;
  assign results.bits_used      = out_bits;
  assign results.final_bits     = out_final;
  assign results.passed_through = out_passed;

endmodule

// ----- rtl/pvdae_checker.sv -----
// ----------------------------------------------------------------------------
// pvdae_checker
// Port-level checks of the embedder core, bound to the top level.
// ----------------------------------------------------------------------------
module pvdae_checker import pvdae_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [15:0]  out_first,
  input logic signed [15:0]  out_second,
  input logic [CAP_W-1:0]    out_bits,
  input logic                out_final,
  input logic                out_passed
);

  logic [1:0] pending;
  logic       in_take, out_take;

  assign in_take  = in_valid && in_ready && (in_opcode == OP_EMBED);
  assign out_take = out_valid && out_ready;

  // embed items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_take) - 2'(out_take);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second))
    else $error("result changed while stalled");

  a_rate: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while results drain");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an embed item");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_passed && !out_final |-> out_bits >= CAP_W'(3))
    else $error("non-final pair below minimum capacity");

endmodule

bind pvd_audio_pair_embedder_core pvdae_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_opcode  (samples.opcode),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_first  (results.first_out),
  .out_second (results.second_out),
  .out_bits   (results.bits_used),
  .out_final  (results.final_bits),
  .out_passed (results.passed_through)
);

// ----- tb/sv/pvdae_pair_checker.sv -----
// ----------------------------------------------------------------------------
// pvdae_pair_checker
// Watches the configuration, sample and result channels of the embedder,
// predicts each embedded pair and compares it field by field.
// ----------------------------------------------------------------------------
module pvdae_pair_checker import pvdae_pkg::*; (
  input  logic clk,
  input  logic rst,
  pvdae_cfg_if cfg,
  pvdae_in_if  samples,
  pvdae_out_if results,
  output int   mismatches,
  output int   pending_pairs,
  output logic stream_finished
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_BITS = HEADER_BITS_DEF;

  typedef struct packed {
    logic signed [15:0] first_out;
    logic signed [15:0] second_out;
    logic [3:0]         bits_used;
    logic               final_bits;
    logic               passed_through;
  } pair_result_t;

  logic [7:0]  msg_store [MAX_MESSAGE_BYTES];
  logic [10:0] bit_pos;
  logic        stream_done;
  logic [6:0]  payload_len;

  pair_result_t expected_pairs [$];

  // next bit of header plus payload at position p
  function automatic logic stream_bit(logic [10:0] p);
    int         count;
    logic [10:0] q;
    logic [7:0]  b;
    if (p < HDR_BITS) begin
      count = int'(payload_len) * 8;
      return 1'((count >> (HDR_BITS - 1 - int'(p))) & 1);
    end
    q = 11'(int'(p) - HDR_BITS);
    b = msg_store[q[9:3]];
    return b[7 - q[2:0]];
  endfunction

  // advance the bit stream by one pair and return the modified pair
  function automatic pair_result_t embed_pair(logic signed [15:0] a, logic signed [15:0] b);
    pair_result_t r;
    int diff, mag, cap, bound, total, remaining, take, value, target, change, half, f, s, i;
    logic last;
    if (stream_done) begin
      r.first_out      = a;
      r.second_out     = b;
      r.bits_used      = '0;
      r.final_bits     = 1'b0;
      r.passed_through = 1'b1;
      return r;
    end
    diff = int'(b) - int'(a);
    mag  = (diff < 0) ? -diff : diff;
    cap  = 3;
    if (mag < 8) begin
      bound = 0;
    end else begin
      while (cap < 15 && (mag >> (cap + 1)) != 0) cap++;
      bound = 1 << cap;
    end
    total     = HDR_BITS + int'(payload_len) * 8;
    remaining = (int'(bit_pos) < total) ? total - int'(bit_pos) : 0;
    take      = cap;
    last      = 1'b0;
    if (remaining <= cap) begin
      take = remaining;
      last = 1'b1;
    end
    value = 0;
    for (i = 0; i < take; i++) begin
      value   = (value << 1) | int'(stream_bit(bit_pos));
      bit_pos = bit_pos + 1'b1;
    end
    target = value + bound;
    if (diff < 0) target = -target;
    change = target - diff;
    half   = change / 2;
    f      = int'(a);
    s      = int'(b);
    if (change % 2 == 0) f -= half;
    else if (change >= 0) f -= half + 1;
    else f -= half - 1;
    s += half;
    if (last) stream_done = 1'b1;
    r.first_out      = f[15:0];
    r.second_out     = s[15:0];
    r.bits_used      = take[3:0];
    r.final_bits     = last;
    r.passed_through = 1'b0;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] e,
                                      logic signed [31:0] g);
    if (g !== e) begin
      $error("%s: expected %0d, got %0d", name, e, g);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pair_result_t exp_r;
    if (rst) begin
      bit_pos     = '0;
      stream_done = 1'b0;
      payload_len = '0;
      mismatches  = 0;
      expected_pairs.delete();
    end else begin
      if (cfg.valid && cfg.ready) payload_len = cfg.payload_bytes;
      if (samples.valid && samples.ready) begin
        case (samples.opcode)
          OP_LOAD:    msg_store[samples.byte_index] = samples.message_byte;
          OP_RESTART: begin
            bit_pos     = '0;
            stream_done = 1'b0;
          end
          OP_EMBED:   expected_pairs.insert(expected_pairs.size(),
                                            embed_pair(samples.first_sample,
                                                       samples.second_sample));
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (expected_pairs.size() == 0) begin
          $error("result item with no pair pending: first_out %0d second_out %0d",
                 results.first_out, results.second_out);
          mismatches++;
        end else begin
          exp_r = expected_pairs.pop_front();
          check_field("first_out", exp_r.first_out, results.first_out);
          check_field("second_out", exp_r.second_out, results.second_out);
          check_field("bits_used", exp_r.bits_used, results.bits_used);
          check_field("final_bits", exp_r.final_bits, results.final_bits);
          check_field("passed_through", exp_r.passed_through, results.passed_through);
        end
      end
    end
    pending_pairs   <= expected_pairs.size();
    stream_finished <= stream_done;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives message loads, payload length writes, restarts and sample pairs into
// the audio pair embedder under random sender gaps and receiver stalls; the
// pair checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pvdae_pkg::*;

  // the package names only the three live opcodes; the fourth is ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1550;
  // idling regimes switch after this many items each
  localparam int PHASE_LEN    = 620;
  // results pass the input and result registers; give loads and restarts slack too
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pvdae_cfg_if cfg_ch ();
  pvdae_in_if  pair_ch ();
  pvdae_out_if res_ch ();

  int   fail_count;
  int   pending_pairs;
  logic stream_finished;

  int   items_sent    = 0;
  int   send_idle_pct = 14;
  int   stall_pct     = 64;
  bit   loaded [MAX_MESSAGE_BYTES];

  pvd_audio_pair_embedder_core u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (pair_ch),
    .results (res_ch)
  );

  pvdae_pair_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_ch),
    .samples         (pair_ch),
    .results         (res_ch),
    .mismatches      (fail_count),
    .pending_pairs   (pending_pairs),
    .stream_finished (stream_finished)
  );

  always #6 clk = ~clk;

  // Result side: drop ready at random, as often as the current regime says.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hand one item to the block. Idle the sender for a random number of
  // cycles first, then hold valid until the block takes the item. Valid is
  // left high on return so back-to-back items run without a gap.
  task automatic send_item(input logic [1:0] op, input logic [6:0] idx,
                           input logic [7:0] data, input logic signed [15:0] a,
                           input logic signed [15:0] b);
    // pick the idling regime from progress: receiver-heavy stalls, then
    // sender-heavy gaps swapped, then none at all
    if (items_sent < PHASE_LEN) begin
      send_idle_pct = 14;
      stall_pct <= 64;
    end else if (items_sent < 2 * PHASE_LEN) begin
      send_idle_pct = 64;
      stall_pct <= 14;
    end else begin
      send_idle_pct = 0;
      stall_pct <= 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pair_ch.valid         <= 1'b1;
    pair_ch.opcode        <= op;
    pair_ch.byte_index    <= idx;
    pair_ch.message_byte  <= data;
    pair_ch.first_sample  <= a;
    pair_ch.second_sample <= b;
    @(posedge clk);
    while (!pair_ch.ready) @(posedge clk);
    // the ignored opcode does not count toward the item budget
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic load_byte(input int idx, input logic [7:0] data);
    send_item(OP_LOAD, idx[6:0], data, 16'($urandom), 16'($urandom));
    loaded[idx] = 1'b1;
  endtask

  task automatic push_pair(input logic signed [15:0] a, input logic signed [15:0] b);
    send_item(OP_EMBED, 7'($urandom), 8'($urandom), a, b);
  endtask

  task automatic restart_stream();
    send_item(OP_RESTART, 7'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Pick a pair whose difference lands in a random one of the 14 ranges,
  // with a quarter of pairs fully random so the wrap-around cases appear.
  task automatic push_random_pair();
    int cls, lo, hi, mag, d, f;
    logic signed [15:0] a, b;
    if ($urandom_range(3) == 0) begin
      a = 16'($urandom);
      b = 16'($urandom);
    end else begin
      cls = $urandom_range(13);
      if (cls == 0) begin
        lo = 0;
        hi = 7;
      end else if (cls == 1) begin
        lo = 8;
        hi = 15;
      end else begin
        lo = 1 << (cls + 2);
        hi = (cls == 13) ? 65535 : (2 << (cls + 2)) - 1;
      end
      mag = int'($urandom_range(hi, lo));
      d   = $urandom_range(1) ? -mag : mag;
      // keep both samples inside 16 bits
      if (d >= 0) f = int'($urandom_range(65535 - d)) - 32768;
      else f = int'($urandom_range(65535 + d)) - 32768 - d;
      a = f[15:0];
      b = 16'(f + d);
    end
    push_pair(a, b);
  endtask

  // Hold off until every predicted pair has come back, then let the
  // pipeline settle so a trailing load or restart has landed too.
  task automatic wait_drained();
    pair_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the payload length with the block idle. Load any store entry the
  // new length would read that was never written first.
  task automatic set_payload_len(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (!loaded[i]) load_byte(i, 8'($urandom));
    end
    wait_drained();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.payload_bytes <= n[6:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int n, pairs, pair_limit, start_count, pick, i;
    bit first_session, mid_change;

    // known values on every input from time zero
    cfg_ch.valid          = 1'b0;
    cfg_ch.payload_bytes  = '0;
    pair_ch.valid         = 1'b0;
    pair_ch.opcode        = OP_LOAD;
    pair_ch.byte_index    = '0;
    pair_ch.message_byte  = '0;
    pair_ch.first_sample  = '0;
    pair_ch.second_sample = '0;
    res_ch.ready          = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed part ----------------
    // ignored opcode with every field bit set
    send_item(OP_UNUSED, 7'h7f, 8'hff, 16'hffff, 16'hffff);
    // extremes of the store index and byte value
    load_byte(0, 8'hff);
    load_byte(127, 8'h00);
    // reset length is zero: the stream is the header alone, ten zero bits
    push_pair(16'sd0, 16'sd0);            // flat pair, three bits
    push_pair(-16'sd32768, 16'sd32767);   // widest positive span takes the rest
    push_pair(16'sd32767, -16'sd32768);   // stream finished: pass through
    restart_stream();
    push_pair(16'sd32767, -16'sd32768);   // widest negative span, whole header
    restart_stream();
    // one payload byte: eighteen bits, header value eight
    set_payload_len(1);
    push_pair(16'sd100, 16'sd108);        // lowest span of the second range
    push_pair(16'sd5, -16'sd11);          // negative span, four bits
    push_pair(-16'sd1, 16'sd6);           // top of the first range
    push_pair(16'sd0, 16'sd16384);        // wide span swallows the last bits
    push_pair(-16'sd20, 16'sd20);         // pass through
    restart_stream();
    // shrink the length mid-stream past the current position: the next pair
    // embeds nothing and closes the stream
    push_pair(16'sd0, 16'sd32767);
    set_payload_len(0);
    push_pair(16'sd1000, -16'sd1000);
    push_pair(-16'sd5, 16'sd7);
    restart_stream();

    // ---------------- random part ----------------
    // Each session loads a message, sets its length, restarts and embeds it
    // to the end with a few pass-through pairs after. Noise sprinkled in:
    // ignored opcodes, stray loads, restarts and length changes mid-stream.
    start_count   = items_sent;
    first_session = 1'b1;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if (first_session) begin
        n = 127;
      end else begin
        pick = $urandom_range(99);
        if (pick < 65) n = $urandom_range(4);
        else if (pick < 90) n = $urandom_range(30, 5);
        else n = $urandom_range(127, 31);
      end
      first_session = 1'b0;

      if ($urandom_range(9) < 4) begin
        for (i = 0; i < n; i++) load_byte(i, 8'($urandom));
      end else begin
        repeat ($urandom_range(3)) load_byte(int'($urandom_range(127)), 8'($urandom));
      end
      set_payload_len(n);
      restart_stream();

      pairs      = 0;
      pair_limit = (10 + 8 * n) / 3 + 4;
      mid_change = ($urandom_range(9) == 0);
      do begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send_item(OP_UNUSED, 7'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 5) begin
          load_byte(int'($urandom_range(127)), 8'($urandom));
        end else if (pick < 6) begin
          restart_stream();
        end else begin
          push_random_pair();
          pairs++;
        end
        if (mid_change && pairs == 3) begin
          set_payload_len(int'($urandom_range(127)));
          mid_change = 1'b0;
        end
      end while (!stream_finished && pairs < pair_limit);

      repeat ($urandom_range(3)) push_random_pair();
    end

    // ---------------- wind down ----------------
    wait_drained();
    if (fail_count == 0) begin
      $display("[pvd_audio_pair_embedder_core] OK");
    end else begin
      $display("[pvd_audio_pair_embedder_core] ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[pvd_audio_pair_embedder_core] ERROR");
    $finish;
  end

endmodule
